// ===== hw/rtl/rart_pkg.sv =====
// ----------------------------------------------------------------------------
// rart_pkg: shared types and constants of the ack/retransmit tracker
// Action and result codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rart_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int ID_W    = 16;
  localparam int TYPE_W  = 16;
  localparam int CRC_W   = 32;
  localparam int CNT_W   = 8;
  localparam int RCNT_W  = 6;
  localparam int LIM_W   = 8;
  localparam logic [LIM_W-1:0] LIMIT_RST = 8'd10;
  localparam logic [CNT_W-1:0] CNT_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    ACT_NEW    = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_EOP    = 2'd2,
    ACT_PACK   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    KIND_ACCEPT = 3'd0,
    KIND_FULL   = 3'd1,
    KIND_RESEND = 3'd2,
    KIND_GIVEUP = 3'd3,
    KIND_DONE   = 3'd4
  } kind_t;

  typedef enum logic [0:0] {
    REG_SKIP_LIMIT   = 1'b0,
    REG_RESEND_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_NEW, S_REPORT, S_EOP, S_GIVEUP, S_RESEND, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    DP_NOP, DP_NEW_WRITE, DP_FULL, DP_REPORT, DP_EOP, DP_GIVEUP, DP_RESEND, DP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
    logic   idx_clr;
    logic   idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic slot_free;
    logic giveup_hit;
    logic resend_hit;
    logic last_idx;
  } dp_stat_t;

endpackage

// ===== hw/rtl/rart_ctrl.sv =====
// ----------------------------------------------------------------------------
// rart_ctrl: sequencing controller
// Accepts one item at a time and steps the datapath through slot sweeps.
// ----------------------------------------------------------------------------
module rart_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  output logic              in_ready,
  input  rart_pkg::dp_stat_t stat,
  output rart_pkg::dp_cmd_t  cmd
);
  import rart_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = DP_NOP;
    cmd.load    = 1'b0;
    cmd.idx_clr = 1'b0;
    cmd.idx_inc = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          unique case (act_t'(in_action))
            ACT_NEW:    state_nxt = S_NEW;
            ACT_REPORT: state_nxt = S_REPORT;
            ACT_EOP:    state_nxt = S_EOP;
            ACT_PACK:   state_nxt = S_GIVEUP;
          endcase
        end
      end
      S_NEW: begin
        if (stat.can_emit) begin
          if (stat.slot_free) begin
            cmd.op    = DP_NEW_WRITE;
            state_nxt = S_IDLE;
          end else if (stat.last_idx) begin
            cmd.op    = DP_FULL;
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_REPORT: begin
        if (stat.can_emit) begin
          cmd.op    = DP_REPORT;
          state_nxt = S_IDLE;
        end
      end
      S_EOP: begin
        if (stat.can_emit) begin
          cmd.op    = DP_EOP;
          state_nxt = S_IDLE;
        end
      end
      S_GIVEUP: begin
        if (stat.can_emit) begin
          if (stat.giveup_hit) cmd.op = DP_GIVEUP;
          if (stat.last_idx) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_RESEND;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_RESEND: begin
        if (stat.can_emit) begin
          if (stat.resend_hit) cmd.op = DP_RESEND;
          if (stat.last_idx) begin
            state_nxt = S_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (stat.can_emit) begin
          cmd.op    = DP_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // work on a slot never runs ahead of the output register
  a_op_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != DP_NOP) |-> stat.can_emit)
    else $error("datapath op issued while output register busy");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("item loaded outside idle");
  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESEND && stat.can_emit && stat.last_idx) |=> (state_r == S_DONE))
    else $error("resend sweep did not end in done");

endmodule

// ===== hw/rtl/rart_dp.sv =====
// ----------------------------------------------------------------------------
// rart_dp: message table, id counter, limits and output register
// Slot index walks the table on command; report and end of packet update
// all slots at once.
// ----------------------------------------------------------------------------
module rart_dp #(
  parameter int TABLE_ENTRIES = rart_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rart_pkg::dp_cmd_t           cmd,
  output rart_pkg::dp_stat_t          stat,
  input  logic [rart_pkg::ID_W-1:0]   in_id,
  input  logic [rart_pkg::TYPE_W-1:0] in_type,
  input  logic [rart_pkg::CRC_W-1:0]  in_crc,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [rart_pkg::LIM_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_kind,
  output logic [rart_pkg::ID_W-1:0]   out_id,
  output logic [rart_pkg::TYPE_W-1:0] out_type,
  output logic [rart_pkg::CRC_W-1:0]  out_crc,
  output logic [rart_pkg::RCNT_W-1:0] out_rcnt,
  output logic                        out_last
);
  import rart_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);

  logic [TABLE_ENTRIES-1:0] valid_r, seen_r, acked_r;
  logic [ID_W-1:0]   id_r    [TABLE_ENTRIES];
  logic [TYPE_W-1:0] type_r  [TABLE_ENTRIES];
  logic [CRC_W-1:0]  crc_r   [TABLE_ENTRIES];
  logic [CNT_W-1:0]  skips_r [TABLE_ENTRIES];
  logic [CNT_W-1:0]  res_r   [TABLE_ENTRIES];

  logic [ID_W-1:0]   m_id_r;
  logic [TYPE_W-1:0] m_type_r;
  logic [CRC_W-1:0]  m_crc_r;
  logic [ID_W-1:0]   next_id_r;
  logic [IdxW-1:0]   idx_r;
  logic [RCNT_W-1:0] rcnt_r;
  logic [LIM_W-1:0]  skip_lim_r, res_lim_r;

  logic              ov_r, olast_r;
  kind_t             okind_r;
  logic [ID_W-1:0]   oid_r;
  logic [TYPE_W-1:0] otype_r;
  logic [CRC_W-1:0]  ocrc_r;
  logic [RCNT_W-1:0] orcnt_r;

  logic              skip_due, res_due, emit;

  assign skip_due = skips_r[idx_r] >= skip_lim_r;
  assign res_due  = res_r[idx_r] >= res_lim_r;
  assign emit     = (cmd.op != DP_NOP);

  assign stat.can_emit   = !ov_r || out_ready;
  assign stat.slot_free  = !valid_r[idx_r];
  assign stat.giveup_hit = valid_r[idx_r] && skip_due && res_due;
  assign stat.resend_hit = valid_r[idx_r] && skip_due;
  assign stat.last_idx   = (idx_r == IdxW'(TABLE_ENTRIES - 1));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      seen_r     <= '0;
      acked_r    <= '0;
      next_id_r  <= '0;
      idx_r      <= '0;
      rcnt_r     <= '0;
      ov_r       <= 1'b0;
      skip_lim_r <= LIMIT_RST;
      res_lim_r  <= LIMIT_RST;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_SKIP_LIMIT:   skip_lim_r <= cfg_wdata;
          REG_RESEND_LIMIT: res_lim_r  <= cfg_wdata;
        endcase
      end
      if (cmd.idx_clr)      idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.load)                 rcnt_r <= '0;
      else if (cmd.op == DP_RESEND) rcnt_r <= rcnt_r + 1'b1;
      if (emit)           ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cmd.op == DP_NEW_WRITE) next_id_r <= next_id_r + 1'b1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        unique case (cmd.op)
          DP_NEW_WRITE, DP_GIVEUP: begin
            if (idx_r == IdxW'(i)) begin
              valid_r[i] <= (cmd.op == DP_NEW_WRITE);
              seen_r[i]  <= 1'b0;
              acked_r[i] <= 1'b0;
            end
          end
          DP_REPORT: begin
            if (valid_r[i] && !seen_r[i] && id_r[i] == m_id_r) begin
              seen_r[i] <= 1'b1;
              if (type_r[i] == m_type_r && crc_r[i] == m_crc_r) acked_r[i] <= 1'b1;
            end
          end
          DP_EOP: begin
            if (valid_r[i] && acked_r[i]) valid_r[i] <= 1'b0;
            seen_r[i]  <= 1'b0;
            acked_r[i] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_id_r   <= in_id;
      m_type_r <= in_type;
      m_crc_r  <= in_crc;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cmd.op == DP_NEW_WRITE && idx_r == IdxW'(i)) begin
        id_r[i]    <= next_id_r;
        type_r[i]  <= m_type_r;
        crc_r[i]   <= m_crc_r;
        skips_r[i] <= '0;
        res_r[i]   <= '0;
      end else if (cmd.op == DP_RESEND && idx_r == IdxW'(i)) begin
        skips_r[i] <= '0;
        if (res_r[i] != CNT_MAX) res_r[i] <= res_r[i] + 1'b1;
      end else if (cmd.op == DP_EOP && valid_r[i] && !acked_r[i] && !seen_r[i] &&
                   skips_r[i] != CNT_MAX) begin
        skips_r[i] <= skips_r[i] + 1'b1;
      end
    end
    if (emit) begin
      unique case (cmd.op)
        DP_NEW_WRITE: begin
          okind_r <= KIND_ACCEPT;
          oid_r   <= next_id_r;
          otype_r <= '0;
          ocrc_r  <= '0;
          orcnt_r <= '0;
          olast_r <= 1'b1;
        end
        DP_FULL: begin
          okind_r <= KIND_FULL;
          oid_r   <= '0;
          otype_r <= '0;
          ocrc_r  <= '0;
          orcnt_r <= '0;
          olast_r <= 1'b1;
        end
        DP_GIVEUP, DP_RESEND: begin
          okind_r <= (cmd.op == DP_GIVEUP) ? KIND_GIVEUP : KIND_RESEND;
          oid_r   <= id_r[idx_r];
          otype_r <= type_r[idx_r];
          ocrc_r  <= crc_r[idx_r];
          orcnt_r <= '0;
          olast_r <= 1'b0;
        end
        DP_DONE: begin
          okind_r <= KIND_DONE;
          oid_r   <= '0;
          otype_r <= '0;
          ocrc_r  <= '0;
          orcnt_r <= rcnt_r;
          olast_r <= 1'b1;
        end
        default: begin
          // report and end of packet
          okind_r <= KIND_DONE;
          oid_r   <= '0;
          otype_r <= '0;
          ocrc_r  <= '0;
          orcnt_r <= '0;
          olast_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_id    = oid_r;
  assign out_type  = otype_r;
  assign out_crc   = ocrc_r;
  assign out_rcnt  = orcnt_r;
  assign out_last  = olast_r;

  a_seen_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r & ~valid_r) == '0)
    else $error("seen flag on a free slot");
  a_acked_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (acked_r & ~seen_r) == '0)
    else $error("acked flag without seen");
  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_NEW_WRITE) |=> (next_id_r == $past(next_id_r) + 1'b1))
    else $error("id counter did not advance");

endmodule

// ===== hw/rtl/reliable_ack_retransmit_tracker_core.sv =====
// ----------------------------------------------------------------------------
// reliable_ack_retransmit_tracker_core: reliable message ack/resend tracker
// Tracks sent reliable messages and reports resends and given-up entries.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects the action (new message, received report,
// end of packet, pack); in_tdata carries id, type and checksum. Results leave
// on the output stream with the kind in out_tuser and out_tlast on the final
// result of each item. Limits must be written on the cfg port only while
// idle; the block itself does not enforce this. One item is taken at a time;
// the next is accepted as soon as the previous one has produced its last
// result, even if that result is still waiting. A new message scans for the
// lowest free slot, one slot per cycle; pack runs two slot sweeps, give-up
// then resend, one slot per cycle. Results go through a single output
// register; while a result is waiting and out_tready is low the sweep holds
// on its current slot and no slot state changes.
// Reset clears all slot flags, the id counter and sets both limits to 10.
// ----------------------------------------------------------------------------
module reliable_ack_retransmit_tracker_core #(
  parameter int TABLE_ENTRIES = rart_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // msg_id[15:0], msg_type[31:16], msg_crc[63:32]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_id, out_type, out_crc, resend_count, zero pad
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import rart_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [ID_W-1:0]   o_id;
  logic [TYPE_W-1:0] o_type;
  logic [CRC_W-1:0]  o_crc;
  logic [RCNT_W-1:0] o_rcnt;

  rart_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rart_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_id     (in_tdata[15:0]),
    .in_type   (in_tdata[31:16]),
    .in_crc    (in_tdata[63:32]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_id    (o_id),
    .out_type  (o_type),
    .out_crc   (o_crc),
    .out_rcnt  (o_rcnt),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, o_rcnt, o_crc, o_type, o_id};

endmodule
